/* rtl/core/lpf_pkg.sv */
package lpf_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int MAX_SPAN    = 64;
  localparam int AW          = $clog2(MAX_SAMPLES);
  localparam int SPAN_W      = 7;
  localparam int LEN_W       = 13;
  localparam int CFG_W       = 13;
  localparam int UPC_W       = 5;

  localparam logic [1:0] CFG_DEGREE = 2'd0;
  localparam logic [1:0] CFG_SPAN   = 2'd1;
  localparam logic [1:0] CFG_SERIES = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SING  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // degree 1 program starts at 0, degree 2 program at this address
  localparam logic [UPC_W-1:0] UPC_DEG2 = 5'd6;

  typedef enum logic [4:0] {
    S_IDLE, S_ADDR, S_X, S_TDIV, S_T1, S_T2, S_U1, S_U2, S_W, S_XW,
    S_X2, S_X3, S_X4, S_Y0, S_Y1, S_Y2, S_ACC, S_SUMS, S_MUL, S_MACC,
    S_CHK, S_DF, S_DS
  } state_t;

  typedef enum logic [3:0] {
    OP_A, OP_B, OP_C, OP_D, OP_E, OP_Y0, OP_Y1, OP_Y2,
    OP_K1, OP_K2, OP_K3, OP_L2, OP_L3
  } opnd_t;

  typedef enum logic [2:0] {
    DS_K1, DS_K2, DS_K3, DS_L2, DS_L3, DS_DET, DS_FN, DS_SN
  } dest_t;

  typedef struct packed {
    opnd_t opa;
    opnd_t opb;
    logic  neg;
    logic  last;
    logic  fin;
    dest_t dest;
  } uop_t;

  typedef struct packed {
    logic              start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) return Q_MAX;
    if (v < -66'sh0_8000_0000) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic uop_t mk(input opnd_t a, input opnd_t b, input logic n,
                              input logic l, input logic f, input dest_t d);
    uop_t u;
    u.opa = a; u.opb = b; u.neg = n; u.last = l; u.fin = f; u.dest = d;
    return u;
  endfunction

  // solver program: each step adds or subtracts one product
  function automatic uop_t uop_rom(input logic [UPC_W-1:0] a);
    case (a)
      5'd0:  return mk(OP_A,  OP_C,  1'b0, 1'b0, 1'b0, DS_DET);
      5'd1:  return mk(OP_B,  OP_B,  1'b1, 1'b1, 1'b0, DS_DET);
      5'd2:  return mk(OP_C,  OP_Y0, 1'b0, 1'b0, 1'b0, DS_FN);
      5'd3:  return mk(OP_B,  OP_Y1, 1'b1, 1'b1, 1'b0, DS_FN);
      5'd4:  return mk(OP_A,  OP_Y1, 1'b0, 1'b0, 1'b0, DS_SN);
      5'd5:  return mk(OP_B,  OP_Y0, 1'b1, 1'b1, 1'b1, DS_SN);
      5'd6:  return mk(OP_E,  OP_C,  1'b0, 1'b0, 1'b0, DS_K1);
      5'd7:  return mk(OP_D,  OP_D,  1'b1, 1'b1, 1'b0, DS_K1);
      5'd8:  return mk(OP_C,  OP_D,  1'b0, 1'b0, 1'b0, DS_K2);
      5'd9:  return mk(OP_E,  OP_B,  1'b1, 1'b1, 1'b0, DS_K2);
      5'd10: return mk(OP_B,  OP_D,  1'b0, 1'b0, 1'b0, DS_K3);
      5'd11: return mk(OP_C,  OP_C,  1'b1, 1'b1, 1'b0, DS_K3);
      5'd12: return mk(OP_E,  OP_A,  1'b0, 1'b0, 1'b0, DS_L2);
      5'd13: return mk(OP_C,  OP_C,  1'b1, 1'b1, 1'b0, DS_L2);
      5'd14: return mk(OP_B,  OP_C,  1'b0, 1'b0, 1'b0, DS_L3);
      5'd15: return mk(OP_D,  OP_A,  1'b1, 1'b1, 1'b0, DS_L3);
      5'd16: return mk(OP_A,  OP_K1, 1'b0, 1'b0, 1'b0, DS_DET);
      5'd17: return mk(OP_B,  OP_K2, 1'b0, 1'b0, 1'b0, DS_DET);
      5'd18: return mk(OP_C,  OP_K3, 1'b0, 1'b1, 1'b0, DS_DET);
      5'd19: return mk(OP_K1, OP_Y0, 1'b0, 1'b0, 1'b0, DS_FN);
      5'd20: return mk(OP_K2, OP_Y1, 1'b0, 1'b0, 1'b0, DS_FN);
      5'd21: return mk(OP_K3, OP_Y2, 1'b0, 1'b1, 1'b0, DS_FN);
      5'd22: return mk(OP_K2, OP_Y0, 1'b0, 1'b0, 1'b0, DS_SN);
      5'd23: return mk(OP_L2, OP_Y1, 1'b0, 1'b0, 1'b0, DS_SN);
      5'd24: return mk(OP_L3, OP_Y2, 1'b0, 1'b1, 1'b1, DS_SN);
      default: return mk(OP_A, OP_A, 1'b0, 1'b1, 1'b1, DS_SN);
    endcase
  endfunction

endpackage

/* rtl/core/lpf_smem.sv */
module lpf_smem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [lpf_pkg::AW-1:0]   waddr,
  input  logic signed [31:0]       wtime,
  input  logic signed [31:0]       wval,
  input  logic [23:0]              wwt,
  input  logic                     re,
  input  logic [lpf_pkg::AW-1:0]   raddr,
  output logic signed [31:0]       rtime,
  output logic signed [31:0]       rval,
  output logic [23:0]              rwt
);
  import lpf_pkg::*;

  logic signed [31:0] time_mem  [MAX_SAMPLES];
  logic signed [31:0] value_mem [MAX_SAMPLES];
  logic [23:0]        wt_mem    [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr]  <= wtime;
      value_mem[waddr] <= wval;
      wt_mem[waddr]    <= wwt;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rtime <= time_mem[raddr];
      rval  <= value_mem[raddr];
      rwt   <= wt_mem[raddr];
    end
  end

endmodule

/* rtl/core/lpf_mul.sv */
module lpf_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [31:0] q
);
  import lpf_pkg::*;

  logic signed [65:0] prod;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // arithmetic shift gives floor on negative products
  assign q = sat32(prod >>> 16);

endmodule

/* rtl/core/lpf_div.sv */
module lpf_div (
  input  logic              clk,
  input  logic              rst,
  input  lpf_pkg::div_req_t req,
  output lpf_pkg::div_rsp_t rsp
);
  import lpf_pkg::*;

  logic        busy;
  logic        done;
  logic        neg;
  logic [5:0]  cnt;
  logic [31:0] dmag;
  logic [32:0] rem;
  logic [47:0] qsh;
  logic [32:0] rem_sh;
  logic        fits;
  logic [31:0] nmag;

  assign nmag   = req.num[31] ? 32'(-req.num) : 32'(req.num);
  assign rem_sh = {rem[31:0], qsh[47]};
  assign fits   = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= req.num[31] ^ req.den[31];
        dmag <= req.den[31] ? 32'(-req.den) : 32'(req.den);
        rem  <= '0;
        qsh  <= {nmag, 16'd0};
      end else if (busy) begin
        rem <= fits ? rem_sh - {1'b0, dmag} : rem_sh;
        qsh <= {qsh[46:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.busy = busy;
    rsp.done = done;
    if (!neg) rsp.quo = (qsh > 48'h0000_7FFF_FFFF) ? Q_MAX : qsh[31:0];
    else      rsp.quo = (qsh > 48'h0000_8000_0000) ? Q_MIN : 32'(-qsh[31:0]);
  end

endmodule

/* rtl/core/loess_local_poly_fit_unit.sv */
// Channel     Handshake               Payload
// ---------   ---------------------   -------------------------------------------
// command     start && !busy          action, sample_index, time_value, y_value,
//                                     user_weight, center, left_index, dist_norm
// result      result_valid (1 cycle)  fit_value, slope_value, status
// config      cfg_we                  cfg_index, cfg_data
//
// A load transaction writes the sample memories at its accept edge; busy stays low.
// An evaluate holds busy for each window sample (memory read, distance, tricube
// division, multiply steps; no division when dist_norm is zero), then for the solver
// (a multiply and an accumulate per product, none for degree 0), a check and, unless det is zero, one or two divisions.
// A window past the series end returns status 2 the next cycle with busy low.
// Reset (rst, synchronous) restores control, configuration and sums, not data regs
// or sample memories; the receiver cannot stall: each result is shown for exactly one cycle.
module loess_local_poly_fit_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      action,
  input  logic [11:0]               sample_index,
  input  logic signed [31:0]        time_value,
  input  logic signed [31:0]        y_value,
  input  logic [23:0]               user_weight,
  input  logic signed [15:0]        center,
  input  logic [11:0]               left_index,
  input  logic [30:0]               dist_norm,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [lpf_pkg::CFG_W-1:0] cfg_data,
  output logic                      result_valid,
  output logic signed [31:0]        fit_value,
  output logic signed [31:0]        slope_value,
  output logic [1:0]                status
);
  import lpf_pkg::*;

  state_t state, state_next;

  // configuration
  logic [1:0]        poly_degree;
  logic [SPAN_W-1:0] span_len;
  logic [LEN_W-1:0]  series_len;

  // latched command
  logic signed [15:0] ctr;
  logic [AW-1:0]      left;
  logic [30:0]        md;
  logic [SPAN_W-1:0]  span_r;
  logic [SPAN_W-1:0]  window_pos;

  // per-sample working values
  logic signed [31:0] x, t, u, w, xw, x2w;
  logic signed [63:0] msum [5];
  logic signed [63:0] rsum [3];

  // solver registers
  logic signed [31:0] opv [13];
  logic signed [31:0] opv_k1, opv_k2, opv_k3, opv_l2, opv_l3;
  logic signed [31:0] det, fnum, snum, fit_hold;
  logic signed [33:0] acc;
  logic [UPC_W-1:0]   upc;
  uop_t               uop;

  // span clip and window check on the incoming command
  logic [SPAN_W-1:0] span_c;
  logic [LEN_W-1:0]  limit_c;
  logic              range_bad;
  logic              accept;

  logic signed [31:0] rtime, rval;
  logic [23:0]        rwt;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] qm;
  logic signed [31:0] u_c;
  logic signed [31:0] x_c, r_c;
  logic signed [32:0] xdiff;
  logic signed [33:0] term, acc_new;

  div_req_t dreq;
  div_rsp_t drsp;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    span_c = span_len;
    if (span_c > SPAN_W'(MAX_SPAN)) span_c = SPAN_W'(MAX_SPAN);
    if (LEN_W'(span_c) > series_len) span_c = series_len[SPAN_W-1:0];
    limit_c = (series_len < LEN_W'(MAX_SAMPLES)) ? series_len : LEN_W'(MAX_SAMPLES);
    range_bad = (LEN_W'(left_index) + LEN_W'(span_c)) > limit_c;
  end

  lpf_smem u_mem (
    .clk   (clk),
    .we    (accept && !action),
    .waddr (sample_index),
    .wtime (time_value),
    .wval  (y_value),
    .wwt   (user_weight),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rtime (rtime),
    .rval  (rval),
    .rwt   (rwt)
  );

  lpf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .q(qm));

  lpf_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // distance of the sample from center, clamped magnitude
  assign xdiff = {rtime[31], rtime} - {ctr[15], ctr, 16'd0};
  assign x_c   = sat32(66'(xdiff));
  assign r_c   = x_c[31] ? ((x_c == Q_MIN) ? Q_MAX : -x_c) : x_c;
  assign u_c   = sat32(66'(Q_ONE) - 66'(qm));

  assign opv[OP_A]  = sat32(66'(msum[0]));
  assign opv[OP_B]  = sat32(66'(msum[1]));
  assign opv[OP_C]  = sat32(66'(msum[2]));
  assign opv[OP_D]  = sat32(66'(msum[3]));
  assign opv[OP_E]  = sat32(66'(msum[4]));
  assign opv[OP_Y0] = sat32(66'(rsum[0]));
  assign opv[OP_Y1] = sat32(66'(rsum[1]));
  assign opv[OP_Y2] = sat32(66'(rsum[2]));
  assign opv[OP_K1] = opv_k1;
  assign opv[OP_K2] = opv_k2;
  assign opv[OP_K3] = opv_k3;
  assign opv[OP_L2] = opv_l2;
  assign opv[OP_L3] = opv_l3;

  assign uop     = uop_rom(upc);
  assign term    = uop.neg ? -34'(qm) : 34'(qm);
  assign acc_new = acc + term;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && action && !range_bad)
          state_next = (span_c == '0) ? S_SUMS : S_ADDR;
      end
      S_ADDR: state_next = S_X;
      S_X:    state_next = (md == '0) ? S_T1 : S_TDIV;
      S_TDIV: if (drsp.done) state_next = S_T1;
      S_T1:   state_next = S_T2;
      S_T2:   state_next = S_U1;
      S_U1:   state_next = S_U2;
      S_U2:   state_next = S_W;
      S_W:    state_next = S_XW;
      S_XW:   state_next = S_X2;
      S_X2:   state_next = S_X3;
      S_X3:   state_next = S_X4;
      S_X4:   state_next = S_Y0;
      S_Y0:   state_next = S_Y1;
      S_Y1:   state_next = S_Y2;
      S_Y2:   state_next = S_ACC;
      S_ACC:  state_next = (window_pos + 1'b1 == span_r) ? S_SUMS : S_ADDR;
      S_SUMS: state_next = (poly_degree == 2'd0) ? S_CHK : S_MUL;
      S_MUL:  state_next = S_MACC;
      S_MACC: state_next = uop.fin ? S_CHK : S_MUL;
      S_CHK:  state_next = (det == '0) ? S_IDLE : S_DF;
      S_DF:   if (drsp.done) state_next = (poly_degree == 2'd0) ? S_IDLE : S_DS;
      S_DS:   if (drsp.done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls: multiplier operands, memory read, divider start
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mem_re    = 1'b0;
    mem_raddr = left + AW'(window_pos);
    dreq      = '0;
    unique case (state)
      S_ADDR: mem_re = 1'b1;
      S_X: begin
        dreq.start = (md != '0);
        dreq.num   = r_c;
        dreq.den   = {1'b0, md};
      end
      S_T1: begin mul_a = 33'(t);   mul_b = 33'(t);   end
      S_T2: begin mul_a = 33'(qm);  mul_b = 33'(t);   end
      S_U1: begin mul_a = 33'(u_c); mul_b = 33'(u_c); end
      S_U2: begin mul_a = 33'(qm);  mul_b = 33'(u);   end
      S_W:  begin mul_a = 33'(qm);  mul_b = {9'd0, rwt}; end
      S_XW, S_X2, S_X3, S_X4: begin mul_a = 33'(x); mul_b = 33'(qm); end
      S_Y0: begin mul_a = 33'(w);   mul_b = 33'(rval); end
      S_Y1: begin mul_a = 33'(xw);  mul_b = 33'(rval); end
      S_Y2: begin mul_a = 33'(x2w); mul_b = 33'(rval); end
      S_MUL: begin mul_a = 33'(opv[uop.opa]); mul_b = 33'(opv[uop.opb]); end
      S_CHK: begin
        dreq.start = (det != '0);
        dreq.num   = fnum;
        dreq.den   = det;
      end
      S_DF: begin
        dreq.start = drsp.done && (poly_degree != 2'd0);
        dreq.num   = snum;
        dreq.den   = det;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      poly_degree  <= 2'd1;
      span_len     <= SPAN_W'(7);
      series_len   <= LEN_W'(MAX_SAMPLES);
      window_pos   <= '0;
      span_r       <= '0;
      result_valid <= 1'b0;
      acc          <= '0;
      upc          <= '0;
      for (int i = 0; i < 5; i++) msum[i] <= '0;
      for (int i = 0; i < 3; i++) rsum[i] <= '0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEGREE: poly_degree <= cfg_data[1:0];
          CFG_SPAN:   span_len    <= cfg_data[SPAN_W-1:0];
          CFG_SERIES: series_len  <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && action) begin
            ctr  <= center;
            left <= left_index;
            md   <= dist_norm;
            if (range_bad) begin
              // drop the window; sums hold their last values
              result_valid <= 1'b1;
              fit_value    <= '0;
              slope_value  <= '0;
              status       <= ST_RANGE;
            end else begin
              span_r     <= span_c;
              window_pos <= '0;
              for (int i = 0; i < 5; i++) msum[i] <= '0;
              for (int i = 0; i < 3; i++) rsum[i] <= '0;
            end
          end
        end
        S_X: begin
          x <= x_c;
          t <= Q_MAX;
        end
        S_TDIV: if (drsp.done) t <= drsp.quo;
        S_U1: u <= u_c;
        S_XW: begin w   <= qm; msum[0] <= msum[0] + 64'(qm); end
        S_X2: begin xw  <= qm; msum[1] <= msum[1] + 64'(qm); end
        S_X3: begin x2w <= qm; msum[2] <= msum[2] + 64'(qm); end
        S_X4: msum[3] <= msum[3] + 64'(qm);
        S_Y0: msum[4] <= msum[4] + 64'(qm);
        S_Y1: rsum[0] <= rsum[0] + 64'(qm);
        S_Y2: rsum[1] <= rsum[1] + 64'(qm);
        S_ACC: begin
          rsum[2]    <= rsum[2] + 64'(qm);
          window_pos <= window_pos + 1'b1;
        end
        S_SUMS: begin
          // degree 0 divides Y0 by A directly; degree 1 runs the linear program, degrees 2 and 3 the quadratic
          det  <= opv[OP_A];
          fnum <= opv[OP_Y0];
          upc  <= poly_degree[1] ? UPC_DEG2 : '0;
          acc  <= '0;
        end
        S_MACC: begin
          upc <= upc + 1'b1;
          if (uop.last) begin
            acc <= '0;
            case (uop.dest)
              DS_K1:  opv_k1 <= sat32(66'(acc_new));
              DS_K2:  opv_k2 <= sat32(66'(acc_new));
              DS_K3:  opv_k3 <= sat32(66'(acc_new));
              DS_L2:  opv_l2 <= sat32(66'(acc_new));
              DS_L3:  opv_l3 <= sat32(66'(acc_new));
              DS_DET: det    <= sat32(66'(acc_new));
              DS_FN:  fnum   <= sat32(66'(acc_new));
              default: snum  <= sat32(66'(acc_new));
            endcase
          end else begin
            acc <= acc_new;
          end
        end
        S_CHK: begin
          if (det == '0) begin
            result_valid <= 1'b1;
            fit_value    <= '0;
            slope_value  <= '0;
            status       <= ST_SING;
          end
        end
        S_DF: begin
          if (drsp.done) begin
            fit_hold <= drsp.quo;
            if (poly_degree == 2'd0) begin
              result_valid <= 1'b1;
              fit_value    <= drsp.quo;
              slope_value  <= '0;
              status       <= ST_OK;
            end
          end
        end
        S_DS: begin
          if (drsp.done) begin
            result_valid <= 1'b1;
            fit_value    <= fit_hold;
            slope_value  <= drsp.quo;
            status       <= ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // results only appear once the sequencer is back to idle
  a_valid_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("result while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> fit_value == '0 && slope_value == '0)
    else $error("error result carries data");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !drsp.busy) else $error("divider running while idle");

  a_win_bound: assert property (@(posedge clk) disable iff (rst)
    window_pos <= span_r) else $error("window position past span");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_TDIV && !drsp.done |=> state == S_TDIV)
    else $error("left tricube division early");

endmodule
